// ----- design/assert_macros.svh -----
// Assertion helpers included by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every rising edge of clk, and is held off while rst is high.
`define CAU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a signal keeps its value across a cycle in which the output word is stalled.
`define CAU_ASSERT_HELD(label, sig, msg) \
  label: assert property (@(posedge clk) disable iff (rst) \
    out_valid && out_stall |=> $stable(sig)) else $error(msg);

`endif

// ----- design/cau_pkg.sv -----
package cau_pkg;

  // These are the operation codes carried on the op field.
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

endpackage

// ----- design/complex_arithmetic_unit_top.sv -----
// Channel | Direction | Handshake          | Word
// --------+-----------+--------------------+---------------------------------------
// input   | in        | in_valid, in_stall | op, a_re, a_im, b_re, b_im
// output  | out       | out_valid, out_stall | res_re, res_im, div_by_zero, saturated
//
// One word is accepted in every cycle while in_stall is low.
// The restoring divider resolves one quotient bit in each stage.
// Every operation passes through the same stages, so results leave in the order they arrived.
// Reset is synchronous and active high. It clears the valid bits of every stage.
// While the output register holds a word that is stalled, the whole pipeline freezes and
// in_stall is raised. No word is lost or repeated.
`include "assert_macros.svh"

module complex_arithmetic_unit_top import cau_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   op,
  input  logic signed [DATA_WIDTH-1:0] a_re,
  input  logic signed [DATA_WIDTH-1:0] a_im,
  input  logic signed [DATA_WIDTH-1:0] b_re,
  input  logic signed [DATA_WIDTH-1:0] b_im,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] res_re,
  output logic signed [DATA_WIDTH-1:0] res_im,
  output logic                         div_by_zero,
  output logic                         saturated
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * DATA_WIDTH;        // width of one product
  localparam int SW = PW + 1;                // width of a sum of two products
  localparam int NW = SW + FRAC_BITS;        // width of a scaled dividend
  localparam int RW = PW + 1;                // width of a partial remainder
  localparam logic signed [SW-1:0] SMAX = SW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  // This function clips a wide signed value to the data range. The top bit of the result is the saturation flag.
  function automatic logic [W:0] sclip(input logic signed [SW-1:0] x);
    logic [W:0] r;
    if (x > SMAX) begin
      r = {1'b1, WMAX};
    end else if (x < SMIN) begin
      r = {1'b1, WMIN};
    end else begin
      r = {1'b0, x[W-1:0]};
    end
    return r;
  endfunction

  // The pipeline moves forward unless the output register holds a word that is stalled.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage 1 forms the products, the squared magnitude terms, and the add and subtract sums.
  logic                 v1;
  op_t                  s1_op;
  logic signed [PW-1:0] s1_prr, s1_pii, s1_pir, s1_pri, s1_krr, s1_kii;
  logic signed [SW-1:0] s1_as_re, s1_as_im;
  logic signed [W:0]    as_re, as_im;

  always_comb begin
    if (op_t'(op) == OP_SUB) begin
      as_re = {a_re[W-1], a_re} - {b_re[W-1], b_re};
      as_im = {a_im[W-1], a_im} - {b_im[W-1], b_im};
    end else begin
      as_re = {a_re[W-1], a_re} + {b_re[W-1], b_re};
      as_im = {a_im[W-1], a_im} + {b_im[W-1], b_im};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      s1_op    <= op_t'(op);
      s1_prr   <= a_re * b_re;
      s1_pii   <= a_im * b_im;
      s1_pir   <= a_im * b_re;
      s1_pri   <= a_re * b_im;
      s1_krr   <= b_re * b_re;
      s1_kii   <= b_im * b_im;
      s1_as_re <= SW'(as_re);
      s1_as_im <= SW'(as_im);
    end
  end

  // Stage 2 sums the products. The results of add, subtract and multiply are finished here.
  logic                 v2;
  op_t                  s2_op;
  logic signed [SW-1:0] s2_sre, s2_sim;
  logic [PW-1:0]        s2_k;
  logic [W-1:0]         s2_res_re, s2_res_im;
  logic                 s2_sat;
  logic signed [SW-1:0] sre, sim;
  logic [W:0]           cre, cim;

  always_comb begin
    if (s1_op == OP_MUL) begin
      sre = SW'(s1_prr) - SW'(s1_pii);
      sim = SW'(s1_pir) + SW'(s1_pri);
    end else begin
      sre = SW'(s1_prr) + SW'(s1_pii);
      sim = SW'(s1_pir) - SW'(s1_pri);
    end
    if (s1_op == OP_MUL) begin
      cre = sclip(sre >>> FRAC_BITS);
      cim = sclip(sim >>> FRAC_BITS);
    end else begin
      cre = sclip(s1_as_re);
      cim = sclip(s1_as_im);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      s2_op     <= s1_op;
      s2_sre    <= sre;
      s2_sim    <= sim;
      s2_k      <= PW'(s1_krr) + PW'(s1_kii);
      s2_res_re <= cre[W-1:0];
      s2_res_im <= cim[W-1:0];
      s2_sat    <= cre[W] | cim[W];
    end
  end

  // Stage 3 takes the magnitudes and signs of the numerators and scales them by the fraction bits.
  logic          v3;
  logic          s3_div, s3_dz, s3_neg_re, s3_neg_im;
  logic [NW-1:0] s3_n_re, s3_n_im;
  logic [PW-1:0] s3_k;
  logic [W-1:0]  s3_res_re, s3_res_im;
  logic          s3_sat;
  logic [SW-1:0] mag_re, mag_im;

  always_comb begin
    mag_re = s2_sre[SW-1] ? SW'(-s2_sre) : SW'(s2_sre);
    mag_im = s2_sim[SW-1] ? SW'(-s2_sim) : SW'(s2_sim);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      s3_div    <= (s2_op == OP_DIV);
      s3_dz     <= (s2_op == OP_DIV) && (s2_k == '0);
      s3_neg_re <= s2_sre[SW-1];
      s3_neg_im <= s2_sim[SW-1];
      s3_n_re   <= NW'(mag_re) << FRAC_BITS;
      s3_n_im   <= NW'(mag_im) << FRAC_BITS;
      s3_k      <= s2_k;
      s3_res_re <= s2_res_re;
      s3_res_im <= s2_res_im;
      s3_sat    <= s2_sat;
    end
  end

  // The divider stages follow. Entry 0 checks for overflow and loads the top of the dividend.
  // After that, each stage resolves one quotient bit for the real part and one for the imaginary part.
  logic          dv      [0:W];
  logic [RW-1:0] d_r_re  [0:W];
  logic [RW-1:0] d_r_im  [0:W];
  logic [W-1:0]  d_n_re  [0:W];
  logic [W-1:0]  d_n_im  [0:W];
  logic [W-1:0]  d_q_re  [0:W];
  logic [W-1:0]  d_q_im  [0:W];
  logic [PW-1:0] d_k     [0:W];
  logic          d_ov_re [0:W];
  logic          d_ov_im [0:W];
  logic          d_neg_re[0:W];
  logic          d_neg_im[0:W];
  logic          d_div   [0:W];
  logic          d_dz    [0:W];
  logic [W-1:0]  d_res_re[0:W];
  logic [W-1:0]  d_res_im[0:W];
  logic          d_sat   [0:W];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= v3;
    end
    if (en) begin
      d_r_re[0]   <= RW'(s3_n_re >> W);
      d_r_im[0]   <= RW'(s3_n_im >> W);
      d_ov_re[0]  <= (s3_n_re >> W) >= NW'(s3_k);
      d_ov_im[0]  <= (s3_n_im >> W) >= NW'(s3_k);
      d_n_re[0]   <= s3_n_re[W-1:0];
      d_n_im[0]   <= s3_n_im[W-1:0];
      d_q_re[0]   <= '0;
      d_q_im[0]   <= '0;
      d_k[0]      <= s3_k;
      d_neg_re[0] <= s3_neg_re;
      d_neg_im[0] <= s3_neg_im;
      d_div[0]    <= s3_div;
      d_dz[0]     <= s3_dz;
      d_res_re[0] <= s3_res_re;
      d_res_im[0] <= s3_res_im;
      d_sat[0]    <= s3_sat;
    end
  end

  for (genvar j = 1; j <= W; j++) begin : g_div
    logic [RW-1:0] t_re, t_im;
    logic          ge_re, ge_im;

    always_comb begin
      t_re  = {d_r_re[j-1][RW-2:0], d_n_re[j-1][W-1]};
      t_im  = {d_r_im[j-1][RW-2:0], d_n_im[j-1][W-1]};
      ge_re = t_re >= RW'(d_k[j-1]);
      ge_im = t_im >= RW'(d_k[j-1]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j] <= 1'b0;
      end else if (en) begin
        dv[j] <= dv[j-1];
      end
      if (en) begin
        d_r_re[j]   <= ge_re ? t_re - RW'(d_k[j-1]) : t_re;
        d_r_im[j]   <= ge_im ? t_im - RW'(d_k[j-1]) : t_im;
        d_q_re[j]   <= {d_q_re[j-1][W-2:0], ge_re};
        d_q_im[j]   <= {d_q_im[j-1][W-2:0], ge_im};
        d_n_re[j]   <= d_n_re[j-1] << 1;
        d_n_im[j]   <= d_n_im[j-1] << 1;
        d_k[j]      <= d_k[j-1];
        d_ov_re[j]  <= d_ov_re[j-1];
        d_ov_im[j]  <= d_ov_im[j-1];
        d_neg_re[j] <= d_neg_re[j-1];
        d_neg_im[j] <= d_neg_im[j-1];
        d_div[j]    <= d_div[j-1];
        d_dz[j]     <= d_dz[j-1];
        d_res_re[j] <= d_res_re[j-1];
        d_res_im[j] <= d_res_im[j-1];
        d_sat[j]    <= d_sat[j-1];
      end
    end
  end

  // For a division, the output stage applies the sign to each quotient and clips it.
  // A zero divisor forces the result to zero.
  logic [W-1:0] q_re, q_im, f_re, f_im;
  logic         sat_re, sat_im;

  always_comb begin
    q_re = d_q_re[W];
    q_im = d_q_im[W];
    if (!d_neg_re[W]) begin
      sat_re = d_ov_re[W] || q_re[W-1];
      f_re   = sat_re ? WMAX : q_re;
    end else begin
      sat_re = d_ov_re[W] || (q_re > WMIN);
      f_re   = sat_re ? WMIN : W'(-q_re);
    end
    if (!d_neg_im[W]) begin
      sat_im = d_ov_im[W] || q_im[W-1];
      f_im   = sat_im ? WMAX : q_im;
    end else begin
      sat_im = d_ov_im[W] || (q_im > WMIN);
      f_im   = sat_im ? WMIN : W'(-q_im);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[W];
    end
    if (en) begin
      if (d_dz[W]) begin
        res_re    <= '0;
        res_im    <= '0;
        saturated <= 1'b0;
      end else if (d_div[W]) begin
        res_re    <= f_re;
        res_im    <= f_im;
        saturated <= sat_re | sat_im;
      end else begin
        res_re    <= d_res_re[W];
        res_im    <= d_res_im[W];
        saturated <= d_sat[W];
      end
      div_by_zero <= d_dz[W];
    end
  end

  // A zero divisor must give a clean zero result with no saturation.
  `CAU_ASSERT(a_dz_zero, out_valid && div_by_zero |-> res_re == '0 && res_im == '0 && !saturated, "divide by zero result not clean")
  // A saturated result must have at least one part pinned at an end of the range.
  `CAU_ASSERT(a_sat_rail, out_valid && saturated |-> res_re == WMAX || res_re == WMIN || res_im == WMAX || res_im == WMIN, "saturation flag without a clipped part")
  // A result word that is stalled must stay put until it is taken.
  `CAU_ASSERT_HELD(a_res_re_held, res_re, "real part changed while stalled")
  `CAU_ASSERT_HELD(a_res_im_held, res_im, "imaginary part changed while stalled")

endmodule

// ----- dv/tb_complex_arithmetic_unit_top.sv -----
`timescale 1ns / 1ps

module tb_complex_arithmetic_unit_top;
  import cau_pkg::*;

  localparam int DW = 16;
  localparam int FB = 8;
  localparam int LATENCY = DW + 5;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_WORDS = 1800;

  // The word that leaves the block, as the predictor works it out.
  typedef struct packed {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    logic                 dz;
    logic                 sat;
  } cplx_result_t;

  // One row of the directed table. When typed is set, the prediction for the
  // row is also compared with the result value written here.
  typedef struct {
    op_t            op;
    logic [DW-1:0]  ar, ai, br, bi;
    bit             typed;
    cplx_result_t   want;
  } directed_row_t;

  logic clk, rst;
  logic in_valid, in_stall;
  logic [1:0] op;
  logic signed [DW-1:0] a_re, a_im, b_re, b_im;
  logic out_valid, out_stall;
  logic signed [DW-1:0] res_re, res_im;
  logic div_by_zero, saturated;

  complex_arithmetic_unit_top #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
    .out_valid(out_valid), .out_stall(out_stall),
    .res_re(res_re), .res_im(res_im),
    .div_by_zero(div_by_zero), .saturated(saturated)
  );

  cplx_result_t pending_results[$];
  cplx_result_t typed_results[$];
  bit           typed_flags[$];
  int errors = 0;
  int words_sent = 0, words_checked = 0;
  int op_count[4] = '{0, 0, 0, 0};
  int dz_seen = 0, sat_seen = 0;
  bit stimulus_done = 0;
  bit hold_off_done = 0;
  int idle_cycles = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Clip a wide signed value to the word range, noting any saturation.
  function automatic logic [DW-1:0] clip_to_word(input logic signed [95:0] v,
                                                 inout logic sat);
    logic signed [95:0] top, bottom;
    top = (96'sd1 <<< (DW - 1)) - 1;
    bottom = -(96'sd1 <<< (DW - 1));
    if (v > top) begin
      sat = 1'b1;
      return top[DW-1:0];
    end
    if (v < bottom) begin
      sat = 1'b1;
      return bottom[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  // Division truncating toward zero on magnitudes, which is what the block's
  // restoring divider does.
  function automatic logic signed [95:0] div_toward_zero(input logic signed [95:0] num,
                                                         input logic signed [95:0] den);
    logic signed [95:0] mag;
    mag = (num < 0 ? -num : num) / den;
    return num < 0 ? -mag : mag;
  endfunction

  function automatic cplx_result_t predict_complex(input op_t code,
      input logic signed [DW-1:0] ar, ai, br, bi);
    cplx_result_t r;
    logic signed [95:0] x, y, k;
    logic sat;
    sat = 1'b0;
    r = '0;
    x = 0;
    y = 0;
    case (code)
      OP_ADD: begin
        x = 96'(ar) + 96'(br);
        y = 96'(ai) + 96'(bi);
      end
      OP_SUB: begin
        x = 96'(ar) - 96'(br);
        y = 96'(ai) - 96'(bi);
      end
      OP_MUL: begin
        // Arithmetic shift: rounds toward minus infinity.
        x = (96'(ar) * 96'(br) - 96'(ai) * 96'(bi)) >>> FB;
        y = (96'(ai) * 96'(br) + 96'(ar) * 96'(bi)) >>> FB;
      end
      default: begin
        k = 96'(br) * 96'(br) + 96'(bi) * 96'(bi);
        if (k == 0) begin
          r.dz = 1'b1;
          return r;
        end
        x = div_toward_zero((96'(ar) * 96'(br) + 96'(ai) * 96'(bi)) <<< FB, k);
        y = div_toward_zero((96'(ai) * 96'(br) - 96'(ar) * 96'(bi)) <<< FB, k);
      end
    endcase
    r.re = clip_to_word(x, sat);
    r.im = clip_to_word(y, sat);
    r.sat = sat;
    return r;
  endfunction

  // Drive one word and hold it until the block takes it.
  task automatic offer_word(input op_t code, input logic [DW-1:0] ar, ai, br, bi,
                            input bit typed, input cplx_result_t want);
    in_valid <= 1'b1;
    op <= code;
    a_re <= ar;
    a_im <= ai;
    b_re <= br;
    b_im <= bi;
    pending_results.push_back(predict_complex(code, ar, ai, br, bi));
    typed_results.push_back(want);
    typed_flags.push_back(typed);
    op_count[code]++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic go_idle(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic [DW-1:0] random_operand();
    // Bias towards the ends of the range and small values, where the corner
    // cases live, with plenty of fully random values too.
    case ($urandom_range(0, 5))
      0: return {1'b0, {(DW-1){1'b1}}};
      1: return {1'b1, {(DW-1){1'b0}}};
      2: return DW'($signed($urandom_range(0, 1024)) - 512);
      3: return '0;
      default: return DW'($urandom);
    endcase
  endfunction

  localparam logic [DW-1:0] MAXV = 16'h7fff;
  localparam logic [DW-1:0] MINV = 16'h8000;
  localparam logic [DW-1:0] ONE  = 16'h0100;

  directed_row_t directed_rows[] = '{
    '{OP_ADD, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, '{16'h0000, 16'h0000, 0, 0}},
    '{OP_ADD, MAXV, MINV, MAXV, MINV, 1, '{MAXV, MINV, 0, 1}},
    '{OP_ADD, MAXV, MINV, MINV, MAXV, 1, '{16'hffff, 16'hffff, 0, 0}},
    '{OP_SUB, MINV, MAXV, 16'h0001, 16'hffff, 1, '{MINV, MAXV, 0, 1}},
    '{OP_SUB, MAXV, MINV, MAXV, MINV, 1, '{16'h0000, 16'h0000, 0, 0}},
    '{OP_MUL, ONE, 16'h0000, ONE, 16'h0000, 1, '{ONE, 16'h0000, 0, 0}},
    '{OP_MUL, MINV, MINV, MINV, MINV, 1, '{16'h0000, MAXV, 0, 1}},
    '{OP_MUL, MAXV, MAXV, MINV, MAXV, 0, '{default: '0}},
    '{OP_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000, 1, '{16'hffff, 16'h0000, 0, 0}},
    '{OP_MUL, 16'h1234, 16'hfedc, 16'h8765, 16'h4321, 0, '{default: '0}},
    '{OP_DIV, MAXV, MINV, 16'h0000, 16'h0000, 1, '{16'h0000, 16'h0000, 1, 0}},
    '{OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, '{16'h0000, 16'h0000, 1, 0}},
    '{OP_DIV, ONE, 16'h0000, ONE, 16'h0000, 1, '{ONE, 16'h0000, 0, 0}},
    '{OP_DIV, MAXV, MAXV, 16'h0001, 16'h0000, 1, '{MAXV, MAXV, 0, 1}},
    '{OP_DIV, MINV, MINV, 16'h0001, 16'h0001, 0, '{default: '0}},
    '{OP_DIV, MINV, MAXV, MINV, MINV, 0, '{default: '0}},
    '{OP_DIV, 16'hffff, 16'h0000, 16'h0300, 16'h0000, 1, '{16'h0000, 16'h0000, 0, 0}},
    '{OP_DIV, 16'h0001, 16'h0000, MAXV, MINV, 0, '{default: '0}},
    '{OP_DIV, 16'h5555, 16'haaaa, 16'h0000, 16'hffff, 0, '{default: '0}},
    '{OP_SUB, 16'haaaa, 16'h5555, 16'h5555, 16'haaaa, 0, '{default: '0}}
  };

  // Stimulus: reset, the directed table back to back, then random bursts.
  initial begin
    int burst;
    in_valid = 0;
    op = '0;
    a_re = '0;
    a_im = '0;
    b_re = '0;
    b_im = '0;
    rst = 1;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (directed_rows[i])
      offer_word(directed_rows[i].op, directed_rows[i].ar, directed_rows[i].ai,
                 directed_rows[i].br, directed_rows[i].bi,
                 directed_rows[i].typed, directed_rows[i].want);
    go_idle(1);

    while (words_sent < directed_rows.size() + RANDOM_WORDS) begin
      burst = $urandom_range(1, 40);
      repeat (burst)
        offer_word(op_t'($urandom_range(0, 3)), random_operand(), random_operand(),
                   random_operand(), random_operand(), 0, '{default: '0});
      // Some bursts run straight into the next, others leave a gap.
      if ($urandom_range(0, 2) != 0) go_idle($urandom_range(1, 6));
    end
    in_valid <= 1'b0;
    stimulus_done = 1;
  end

  // The receiver stalls on its own pattern. Early in the run it holds off for
  // a long stretch so that the pipeline fills and pushes back on the sender.
  initial begin
    int phase;
    out_stall = 1'b0;
    @(negedge rst);
    repeat (60) @(posedge clk);
    out_stall <= 1'b1;
    repeat (3 * LATENCY) @(posedge clk);
    out_stall <= 1'b0;
    hold_off_done = 1;
    forever begin
      phase = $urandom_range(0, 3);
      case (phase)
        0: repeat ($urandom_range(20, 80)) @(posedge clk);
        default: repeat ($urandom_range(1, 30)) begin
          out_stall <= ($urandom_range(0, 2) == 0);
          @(posedge clk);
        end
      endcase
      out_stall <= 1'b0;
    end
  end

  // Compare every accepted result word with the oldest prediction.
  always @(posedge clk) begin
    cplx_result_t want, typed_want;
    bit typed;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word arrived with no prediction waiting");
        errors++;
      end else begin
        want = pending_results.pop_front();
        typed_want = typed_results.pop_front();
        typed = typed_flags.pop_front();
        if (res_re !== want.re) begin
          $error("res_re: expected %0d, got %0d", want.re, res_re);
          errors++;
        end
        if (res_im !== want.im) begin
          $error("res_im: expected %0d, got %0d", want.im, res_im);
          errors++;
        end
        if (div_by_zero !== want.dz) begin
          $error("div_by_zero: expected %0b, got %0b", want.dz, div_by_zero);
          errors++;
        end
        if (saturated !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, saturated);
          errors++;
        end
        // For rows of the directed table with a typed-in result, the prediction is held to it as well.
        if (typed && want !== typed_want) begin
          $error("table row: expected %h, predicted %h", typed_want, want);
          errors++;
        end
        if (div_by_zero) dz_seen++;
        if (saturated) sat_seen++;
        words_checked++;
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(negedge rst);
    wait (stimulus_done && pending_results.size() == 0 || idle_cycles >= WATCHDOG_LIMIT);
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d words outstanding", pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      repeat (2 * LATENCY) @(posedge clk);
      $display("Checked %0d words (add %0d, sub %0d, mul %0d, div %0d).",
               words_checked, op_count[OP_ADD], op_count[OP_SUB],
               op_count[OP_MUL], op_count[OP_DIV]);
      $display("Divide-by-zero seen %0d times, saturation %0d times; long hold-off %s.",
               dz_seen, sat_seen, hold_off_done ? "done" : "missed");
      if (errors == 0 && pending_results.size() == 0)
        $display("Testbench completed without errors");
      else
        $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

// ----- sim.f -----
+incdir+design
design/cau_pkg.sv
design/complex_arithmetic_unit_top.sv
dv/tb_complex_arithmetic_unit_top.sv
